// ===== design/gaa_pkg.sv =====
// ----------------------------------------------------------------------------
// gaa_pkg: shared types and constants
// Widths, sequencer state and multiplier operation codes of the
// gravitational acceleration accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package gaa_pkg;

	localparam int POS_W  = 32;              // Q16.16 position
	localparam int MASS_W = 32;              // unsigned Q16.16
	localparam int G_W    = 32;              // unsigned Q16.16
	localparam int ACC_W  = 48;              // Q24.24 acceleration
	localparam int MAG_W  = 32;              // |ps - pt| always fits 32 bits
	localparam int MUL_W  = 33;              // shared multiplier operand width
	localparam int PROD_W = 2 * MUL_W;       // 66
	localparam int RAD_W  = 66;              // squared distance
	localparam int ROOT_W = 33;              // floor sqrt of squared distance
	localparam int GM_W   = 64;              // g * mass
	localparam int DEN_W  = 99;              // r2 * r
	localparam int NUM_W  = 120;             // g * mass * |d| * 2^24
	localparam int SUM_W  = ACC_W + 2;       // room for sum plus contribution

	localparam logic signed [SUM_W-1:0] SUM_MAX = 50'sd140737488355327;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -50'sd140737488355328;
	localparam logic [G_W-1:0] G_RESET = 32'd65536;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_ADD  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_CHK,
		ST_SQRT,
		ST_DIV,
		ST_SUM,
		ST_DONE
	} gaa_state_t;

	typedef enum logic [2:0] {
		OP_SQX,
		OP_SQY,
		OP_SQZ,
		OP_GM,
		OP_DENLO,
		OP_DENHI,
		OP_NUMLO,
		OP_NUMHI
	} gaa_op_t;

endpackage
`default_nettype wire

// ===== design/gaa_in_if.sv =====
// ----------------------------------------------------------------------------
// gaa_in_if: input item channel
// Valid/ready channel carrying one load or source body item.
// ----------------------------------------------------------------------------
`default_nettype none
interface gaa_in_if;
	import gaa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic        [MASS_W-1:0] mass;
	logic                     last;

	modport source (output valid, func, pos_x, pos_y, pos_z, mass, last, input ready);
	modport sink   (input valid, func, pos_x, pos_y, pos_z, mass, last, output ready);
endinterface
`default_nettype wire

// ===== design/gaa_out_if.sv =====
// ----------------------------------------------------------------------------
// gaa_out_if: result item channel
// Valid/ready channel carrying the summed acceleration vector.
// ----------------------------------------------------------------------------
`default_nettype none
interface gaa_out_if;
	import gaa_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] acc_x;
	logic signed [ACC_W-1:0] acc_y;
	logic signed [ACC_W-1:0] acc_z;
	logic                    saturated;

	modport source (output valid, acc_x, acc_y, acc_z, saturated, input ready);
	modport sink   (input valid, acc_x, acc_y, acc_z, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/gaa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gaa_cfg_if: configuration write channel
// Valid/ready channel carrying the gravitational constant.
// ----------------------------------------------------------------------------
`default_nettype none
interface gaa_cfg_if;
	import gaa_pkg::*;

	logic           valid;
	logic           ready;
	logic [G_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/gaa_sqrt.sv =====
// ----------------------------------------------------------------------------
// gaa_sqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gaa_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [gaa_pkg::RAD_W-1:0]  rad,
	output logic                            done,
	output logic      [gaa_pkg::ROOT_W-1:0] root
);
	import gaa_pkg::*;

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  cur;
	logic [REM_W-1:0]  trial;
	logic              ge;

	// bring down two radicand bits, try appending a one to the root
	assign cur   = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (cur - trial) : cur;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== design/gaa_div.sv =====
// ----------------------------------------------------------------------------
// gaa_div: iterative divider with early overflow
// Restoring division giving a 48-bit quotient or an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none
module gaa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gaa_pkg::NUM_W-1:0] num,
	input  wire logic [gaa_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic                           ovf,
	output logic      [gaa_pkg::ACC_W-1:0] quo
);
	import gaa_pkg::*;

	localparam int HI_W  = NUM_W - ACC_W;
	localparam int CNT_W = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [ACC_W-1:0] sh_q;
	logic [DEN_W-1:0] num_hi;
	logic             big;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// quotient needs more than 48 bits exactly when the top part reaches den
	assign num_hi = {{(DEN_W - HI_W){1'b0}}, num[NUM_W-1 -: HI_W]};
	assign big    = (num_hi >= den);
	assign trial  = {rem_q, sh_q[ACC_W-1]};
	assign diff   = trial - {1'b0, den};
	assign ge     = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ovf_q  <= big;
				busy_q <= !big;
				done_q <= big;
				cnt_q  <= CNT_W'(ACC_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// numerator bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			sh_q  <= num[ACC_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[ACC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = sh_q;

endmodule
`default_nettype wire

// ===== design/gravity_accel_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// gravity_accel_accumulator_unit: pairwise gravitational acceleration sum
// Accumulates g*m*(ps-pt)/r^3 on one target body over a stream of sources.
// ----------------------------------------------------------------------------
// Load item: taken while idle; the block stays idle, so it is ready for the next item.
// Source item: the next item is accepted only after the finish step. Work runs as 12 multiply
//   steps, each a multiply and an accumulate state, a check step, the square root, per axis
//   a divide and a sum step, then the finish step. Zero distance goes from check to finish.
// A source with last set shows its result when the block is ready again; a
//   result still waiting holds the finish step. Reset clears control state, target and sums, g = 1.0.
`default_nettype none
module gravity_accel_accumulator_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gaa_in_if.sink     din,
	gaa_out_if.source  dout,
	gaa_cfg_if.sink    cfg
);
	import gaa_pkg::*;

	// ---------------------------------------------------------------- state
	gaa_state_t state_q, state_d;
	gaa_op_t    op_q;
	logic [1:0] axis_q;
	logic       last_q;

	// architectural state
	logic [G_W-1:0]          g_q;
	logic signed [POS_W-1:0] tgt_q [3];
	logic signed [ACC_W-1:0] sum_q [3];
	logic                    clip_q;

	// per-source working registers
	logic [MAG_W-1:0]  mag_q [3];
	logic              neg_q [3];
	logic [MASS_W-1:0] mass_q;
	logic [PROD_W-1:0] prod_q;
	logic [RAD_W-1:0]  r2_q;
	logic [GM_W-1:0]   gm_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;

	// result register
	logic                    out_vld_q;
	logic signed [ACC_W-1:0] out_x_q, out_y_q, out_z_q;
	logic                    out_sat_q;

	// control outputs of the sequencer
	logic in_rdy, sqrt_go, div_go;
	logic div_go_q;

	// unit results
	logic              sqrt_done, div_done, div_ovf;
	logic [ROOT_W-1:0] root;
	logic [ACC_W-1:0]  quo;

	// ---------------------------------------------------- input differences
	logic signed [POS_W:0] diff [3];
	logic signed [POS_W:0] dneg [3];
	logic signed [POS_W-1:0] pos_in [3];

	assign pos_in[0] = din.pos_x;
	assign pos_in[1] = din.pos_y;
	assign pos_in[2] = din.pos_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {pos_in[i][POS_W-1], pos_in[i]} - {tgt_q[i][POS_W-1], tgt_q[i]};
			dneg[i] = -diff[i];
		end
	end

	// ------------------------------------------------- shared multiplier mux
	logic [MUL_W-1:0] mul_a, mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_SQX: begin
				mul_a = {1'b0, mag_q[0]};
				mul_b = {1'b0, mag_q[0]};
			end
			OP_SQY: begin
				mul_a = {1'b0, mag_q[1]};
				mul_b = {1'b0, mag_q[1]};
			end
			OP_SQZ: begin
				mul_a = {1'b0, mag_q[2]};
				mul_b = {1'b0, mag_q[2]};
			end
			OP_GM: begin
				mul_a = {1'b0, g_q};
				mul_b = {1'b0, mass_q};
			end
			OP_DENLO: begin
				mul_a = r2_q[MUL_W-1:0];
				mul_b = root;
			end
			OP_DENHI: begin
				mul_a = r2_q[RAD_W-1:MUL_W];
				mul_b = root;
			end
			OP_NUMLO: begin
				mul_a = gm_q[MUL_W-1:0];
				mul_b = {1'b0, mag_q[axis_q]};
			end
			OP_NUMHI: begin
				mul_a = {{(2 * MUL_W - GM_W){1'b0}}, gm_q[GM_W-1:MUL_W]};
				mul_b = {1'b0, mag_q[axis_q]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---------------------------------------------------- contribution + sum
	logic signed [SUM_W-1:0] cval, sval, sclamp;
	logic                    cclip, sclip;

	always_comb begin
		// signed contribution, clamped to the Q24.24 range
		if (!neg_q[axis_q]) begin
			cclip = div_ovf | quo[ACC_W-1];
			cval  = cclip ? SUM_MAX : $signed({2'b00, quo});
		end else begin
			cclip = div_ovf | (quo[ACC_W-1] & (|quo[ACC_W-2:0]));
			cval  = cclip ? SUM_MIN : -$signed({2'b00, quo});
		end
		sval  = $signed({{2{sum_q[axis_q][ACC_W-1]}}, sum_q[axis_q]}) + cval;
		sclip = 1'b0;
		if (sval > SUM_MAX) begin
			sclamp = SUM_MAX;
			sclip  = 1'b1;
		end else if (sval < SUM_MIN) begin
			sclamp = SUM_MIN;
			sclip  = 1'b1;
		end else begin
			sclamp = sval;
		end
	end

	// ------------------------------------------------------ sequencer: next
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (din.valid && din.func == FUNC_ADD) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				case (op_q)
					OP_SQZ:   state_d = ST_CHK;
					OP_NUMHI: state_d = ST_DIV;
					default:  state_d = ST_MUL;
				endcase
			end
			ST_CHK: begin
				state_d = (r2_q == '0) ? ST_DONE : ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_MUL;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = (axis_q == 2'd2) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				// hold a final source while a previous result still waits to be taken
				if (!last_q || !out_vld_q || dout.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// --------------------------------------------------- sequencer: outputs
	always_comb begin
		in_rdy  = (state_q == ST_IDLE);
		sqrt_go = (state_q == ST_CHK) && (r2_q != '0);
		// start the divider once the full numerator sits in num_q
		div_go  = div_go_q;
	end

	// --------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_SQX;
			axis_q    <= '0;
			last_q    <= 1'b0;
			g_q       <= G_RESET;
			clip_q    <= 1'b0;
			out_vld_q <= 1'b0;
			div_go_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tgt_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			div_go_q <= (state_q == ST_ACC) && (op_q == OP_NUMHI);

			if (cfg.valid) begin
				g_q <= cfg.data;
			end

			// take an item: load target and clear, or start a source
			if (in_rdy && din.valid) begin
				if (din.func == FUNC_LOAD) begin
					for (int i = 0; i < 3; i++) begin
						tgt_q[i] <= pos_in[i];
						sum_q[i] <= '0;
					end
					clip_q <= 1'b0;
				end else begin
					op_q   <= OP_SQX;
					axis_q <= '0;
					last_q <= din.last;
				end
			end

			// advance the operation code, except after the last product
			if (state_q == ST_ACC && op_q != OP_NUMHI) begin
				op_q <= gaa_op_t'(op_q + 3'd1);
			end

			if (state_q == ST_SUM) begin
				sum_q[axis_q] <= sclamp[ACC_W-1:0];
				clip_q        <= clip_q | cclip | sclip;
				op_q          <= OP_NUMLO;
				axis_q        <= axis_q + 2'd1;
			end

			// emit on the final source, drop once taken
			if (state_q == ST_DONE && state_d == ST_IDLE && last_q) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		if (in_rdy && din.valid && din.func == FUNC_ADD) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= diff[i][POS_W] ? dneg[i][MAG_W-1:0] : diff[i][MAG_W-1:0];
				neg_q[i] <= diff[i][POS_W];
			end
			mass_q <= din.mass;
		end

		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
		end

		// fold the registered product into its destination
		if (state_q == ST_ACC) begin
			case (op_q)
				OP_SQX:   r2_q  <= prod_q;
				OP_SQY:   r2_q  <= r2_q + prod_q;
				OP_SQZ:   r2_q  <= r2_q + prod_q;
				OP_GM:    gm_q  <= prod_q[GM_W-1:0];
				OP_DENLO: den_q <= {{(DEN_W - PROD_W){1'b0}}, prod_q};
				OP_DENHI: den_q <= den_q + {prod_q, {MUL_W{1'b0}}};
				OP_NUMLO: num_q <= {{(NUM_W - PROD_W){1'b0}}, prod_q};
				OP_NUMHI: num_q <= num_q
					+ {{(NUM_W - PROD_W - MUL_W){1'b0}}, prod_q, {MUL_W{1'b0}}};
				default: begin
				end
			endcase
		end

		if (state_q == ST_DONE && state_d == ST_IDLE && last_q) begin
			out_x_q   <= sum_q[0];
			out_y_q   <= sum_q[1];
			out_z_q   <= sum_q[2];
			out_sat_q <= clip_q;
		end
	end

	// num_q shifted left by 24 bits is the dividend
	logic [NUM_W-1:0] dividend;
	assign dividend = {num_q[NUM_W-25:0], 24'd0};

	// ---------------------------------------------------------------- units
	gaa_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go),
		.rad    (r2_q),
		.done   (sqrt_done),
		.root   (root)
	);

	gaa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (dividend),
		.den    (den_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (quo)
	);

	// ---------------------------------------------------------------- ports
	assign din.ready      = in_rdy;
	assign cfg.ready      = 1'b1;
	assign dout.valid     = out_vld_q;
	assign dout.acc_x     = out_x_q;
	assign dout.acc_y     = out_y_q;
	assign dout.acc_z     = out_z_q;
	assign dout.saturated = out_sat_q;

	// ----------------------------------------------------------- assertions
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_sqrt_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQRT)
		else $error("square root finished outside the root step");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && state_d == ST_IDLE && last_q) |=> dout.valid)
		else $error("final source gave no result item");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_SQRT) |-> !din.ready)
		else $error("input ready while a source is in work");

endmodule
`default_nettype wire
